// File: design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property that holds at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Property that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// File: design/sha256_pkg.sv
`default_nettype none
package sha256_pkg;

    // Controller states.
    typedef enum logic [2:0] {
        ST_COLLECT,
        ST_PAD,
        ST_ROUNDS,
        ST_UPDATE,
        ST_EMIT
    } t_state;

    // Datapath commands from the controller.
    typedef struct packed {
        logic take_byte;    // write input byte into buffer, bump count
        logic pad_init;     // write 0x80 and clear the tail
        logic pad_clear;    // clear the whole buffer (extra block)
        logic put_length;   // write the bit length into bytes 56..63
        logic round_start;  // load working registers from chain
        logic round_step;   // run one round
        logic chain_add;    // add working registers into chain
        logic emit_shift;   // shift digest out by one word
        logic reload;       // reload initial hash, clear count
    } t_cmd;

    // Datapath status to the controller.
    typedef struct packed {
        logic [5:0] fill;      // byte position in current block
        logic       rounds_done;
    } t_status;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

endpackage
`default_nettype wire

// File: design/sha256_ctrl.sv
`default_nettype none
module sha256_ctrl (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    input  wire                    i_has_byte,
    input  wire                    i_end_of_message,
    output logic                   o_stall,
    output logic                   o_valid,
    output logic [2:0]             o_word_index,
    output logic                   o_last_word,
    input  wire                    i_stall,
    output sha256_pkg::t_cmd       o_cmd,
    input  sha256_pkg::t_status    i_status
);

    sha256_pkg::t_state r_state, n_state;
    logic r_final, n_final;   // current compression finishes the message
    logic r_extra, n_extra;   // a length-only block still follows
    logic r_pend_end, n_pend_end; // byte filled a block and end was also set
    logic [2:0] r_idx, n_idx;
    logic accept;

    assign accept = i_valid && !o_stall;

    // State and bookkeeping registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= sha256_pkg::ST_COLLECT;
            r_final    <= 1'b0;
            r_extra    <= 1'b0;
            r_pend_end <= 1'b0;
            r_idx      <= '0;
        end else begin
            r_state    <= n_state;
            r_final    <= n_final;
            r_extra    <= n_extra;
            r_pend_end <= n_pend_end;
            r_idx      <= n_idx;
        end
    end

    // Next state.
    always_comb begin
        n_state    = r_state;
        n_final    = r_final;
        n_extra    = r_extra;
        n_pend_end = r_pend_end;
        n_idx      = r_idx;
        unique case (r_state)
            sha256_pkg::ST_COLLECT: begin
                if (accept) begin
                    if (i_has_byte && i_status.fill == 6'd63) begin
                        n_state    = sha256_pkg::ST_ROUNDS;
                        n_final    = 1'b0;
                        n_pend_end = i_end_of_message;
                    end else if (i_end_of_message) begin
                        n_state = sha256_pkg::ST_PAD;
                    end
                end
            end
            sha256_pkg::ST_PAD: begin
                // fill here already counts any byte of the ending word
                n_state    = sha256_pkg::ST_ROUNDS;
                n_pend_end = 1'b0;
                n_extra    = (i_status.fill >= sha256_pkg::LEN_POS);
                n_final    = (i_status.fill < sha256_pkg::LEN_POS);
            end
            sha256_pkg::ST_ROUNDS: begin
                if (i_status.rounds_done) n_state = sha256_pkg::ST_UPDATE;
            end
            sha256_pkg::ST_UPDATE: begin
                if (r_final) begin
                    n_state = sha256_pkg::ST_EMIT;
                    n_idx   = '0;
                end else if (r_extra) begin
                    n_state = sha256_pkg::ST_ROUNDS;
                    n_extra = 1'b0;
                    n_final = 1'b1;
                end else if (r_pend_end) begin
                    n_state = sha256_pkg::ST_PAD;
                end else begin
                    n_state = sha256_pkg::ST_COLLECT;
                end
            end
            sha256_pkg::ST_EMIT: begin
                if (!i_stall) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        n_state = sha256_pkg::ST_COLLECT;
                        n_final = 1'b0;
                    end
                end
            end
            default: n_state = sha256_pkg::ST_COLLECT;
        endcase
    end

    // Outputs and datapath commands.
    always_comb begin
        o_cmd        = '0;
        o_stall      = 1'b1;
        o_valid      = 1'b0;
        o_word_index = r_idx;
        o_last_word  = (r_idx == 3'd7);
        unique case (r_state)
            sha256_pkg::ST_COLLECT: begin
                o_stall = 1'b0;
                o_cmd.take_byte  = accept && i_has_byte;
                o_cmd.round_start = accept && i_has_byte && i_status.fill == 6'd63;
            end
            sha256_pkg::ST_PAD: begin
                o_cmd.pad_init    = 1'b1;
                o_cmd.put_length  = (i_status.fill < sha256_pkg::LEN_POS);
                o_cmd.round_start = 1'b1;
            end
            sha256_pkg::ST_ROUNDS: begin
                o_cmd.round_step = 1'b1;
            end
            sha256_pkg::ST_UPDATE: begin
                o_cmd.chain_add = 1'b1;
                if (!r_final && r_extra) begin
                    o_cmd.pad_clear   = 1'b1;
                    o_cmd.put_length  = 1'b1;
                    o_cmd.round_start = 1'b1;
                end
            end
            sha256_pkg::ST_EMIT: begin
                o_valid = 1'b1;
                o_cmd.emit_shift = !i_stall;
                o_cmd.reload     = !i_stall && r_idx == 3'd7;
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// File: design/sha256_datapath.sv
`default_nettype none
module sha256_datapath (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire [7:0]              i_msg_byte,
    input  sha256_pkg::t_cmd       i_cmd,
    output sha256_pkg::t_status    o_status,
    output logic [31:0]            o_digest_word
);

    logic [31:0] r_blk [16];
    logic [31:0] n_blk [16];
    logic [31:0] r_w [16];
    logic [31:0] r_h [8];
    logic [31:0] r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_h7;
    logic [60:0] r_count;
    logic [5:0]  r_round;
    logic        r_busy;
    logic [31:0] w_cur, s0, s1, t1, t2;
    logic [63:0] bits;
    logic [5:0]  fill;

    assign fill  = r_count[5:0];
    assign bits  = {r_count, 3'b000};
    assign o_status.fill        = fill;
    assign o_status.rounds_done = (r_round == 6'd63);
    assign o_digest_word = r_h[0];

    // Message schedule: first 16 words come from the buffer, rest from the window.
    always_comb begin
        s0 = sha256_pkg::rotr(r_w[1], 7) ^ sha256_pkg::rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        s1 = sha256_pkg::rotr(r_w[14], 17) ^ sha256_pkg::rotr(r_w[14], 19)
             ^ (r_w[14] >> 10);
        if (r_round < 6'd16)
            w_cur = r_blk[r_round[3:0]];
        else
            w_cur = s1 + r_w[9] + s0 + r_w[0];
        t1 = r_h7 + (sha256_pkg::rotr(r_e, 6) ^ sha256_pkg::rotr(r_e, 11)
             ^ sha256_pkg::rotr(r_e, 25)) + ((r_e & r_f) ^ (~r_e & r_g))
             + w_cur + sha256_pkg::ROUND_K[r_round];
        t2 = (sha256_pkg::rotr(r_a, 2) ^ sha256_pkg::rotr(r_a, 13)
             ^ sha256_pkg::rotr(r_a, 22)) + ((r_a & r_b) ^ (r_a & r_c) ^ (r_b & r_c));
    end

    // Byte count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_count <= '0;
        else if (i_cmd.reload) r_count <= '0;
        else if (i_cmd.take_byte) r_count <= r_count + 61'd1;
    end

    // Round counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_round <= '0;
            r_busy  <= 1'b0;
        end else if (i_cmd.round_start) begin
            r_round <= '0;
            r_busy  <= 1'b1;
        end else if (i_cmd.round_step) begin
            r_round <= r_round + 6'd1;
            r_busy  <= (r_round != 6'd63);
        end
    end

    // Block buffer as 16 big-endian words: byte writes, padding and length.
    // Later commands in this block take priority over earlier ones.
    always_comb begin
        for (int j = 0; j < 16; j++) n_blk[j] = r_blk[j];
        if (i_cmd.take_byte) n_blk[fill[5:2]][{~fill[1:0], 3'b000} +: 8] = i_msg_byte;
        if (i_cmd.pad_clear)
            for (int j = 0; j < 16; j++) n_blk[j] = '0;
        if (i_cmd.pad_init) begin
            for (int k = 0; k < 64; k++) begin
                if (k == int'(fill))
                    n_blk[k >> 2][8 * (3 - (k & 3)) +: 8] = sha256_pkg::PAD_BYTE;
                else if (k > int'(fill))
                    n_blk[k >> 2][8 * (3 - (k & 3)) +: 8] = 8'h00;
            end
        end
        if (i_cmd.put_length) begin
            n_blk[14] = bits[63:32];
            n_blk[15] = bits[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 16; j++) r_blk[j] <= n_blk[j];
    end

    // Schedule window, shifted one word per round.
    always_ff @(posedge i_clk) begin
        if (i_cmd.round_step) begin
            for (int j = 0; j < 15; j++) r_w[j] <= r_w[j + 1];
            r_w[15] <= w_cur;
        end
    end

    // Working registers. A length-only block starts from the chain value
    // that is being updated in the same cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.round_start && i_cmd.chain_add) begin
            r_a <= r_h[0] + r_a; r_b <= r_h[1] + r_b;
            r_c <= r_h[2] + r_c; r_d <= r_h[3] + r_d;
            r_e <= r_h[4] + r_e; r_f <= r_h[5] + r_f;
            r_g <= r_h[6] + r_g; r_h7 <= r_h[7] + r_h7;
        end else if (i_cmd.round_start) begin
            {r_a, r_b, r_c, r_d} <= {r_h[0], r_h[1], r_h[2], r_h[3]};
            {r_e, r_f, r_g, r_h7} <= {r_h[4], r_h[5], r_h[6], r_h[7]};
        end else if (i_cmd.round_step && r_busy) begin
            r_h7 <= r_g; r_g <= r_f; r_f <= r_e; r_e <= r_d + t1;
            r_d <= r_c; r_c <= r_b; r_b <= r_a; r_a <= t1 + t2;
        end
    end

    // Chain value: add, rotate out, reload.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < 8; j++) r_h[j] <= sha256_pkg::INIT_H[j];
        end else if (i_cmd.reload) begin
            for (int j = 0; j < 8; j++) r_h[j] <= sha256_pkg::INIT_H[j];
        end else if (i_cmd.chain_add) begin
            r_h[0] <= r_h[0] + r_a; r_h[1] <= r_h[1] + r_b;
            r_h[2] <= r_h[2] + r_c; r_h[3] <= r_h[3] + r_d;
            r_h[4] <= r_h[4] + r_e; r_h[5] <= r_h[5] + r_f;
            r_h[6] <= r_h[6] + r_g; r_h[7] <= r_h[7] + r_h7;
        end else if (i_cmd.emit_shift) begin
            for (int j = 0; j < 7; j++) r_h[j] <= r_h[j + 1];
            r_h[7] <= r_h[0];
        end
    end

endmodule
`default_nettype wire

// File: design/sha256_stream_hasher.sv
`default_nettype none
// Streaming SHA-256 hasher. One byte word is taken per cycle while a block
// fills; when the 64th byte of a block arrives, intake stalls while the
// single round unit runs 64 rounds and adds into the chain value. At end
// of message the pad state is followed by one or two compressions (two
// when 56 or more bytes are pending), then the eight digest words leave
// one per cycle while the receiver does not stall, word 0 first, with last_word on word 7.
module sha256_stream_hasher (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [7:0]  i_msg_byte,
    input  wire         i_has_byte,
    input  wire         i_end_of_message,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    sha256_pkg::t_cmd    cmd;
    sha256_pkg::t_status status;

    sha256_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .i_has_byte       (i_has_byte),
        .i_end_of_message (i_end_of_message),
        .o_stall          (o_stall),
        .o_valid          (o_valid),
        .o_word_index     (o_word_index),
        .o_last_word      (o_last_word),
        .i_stall          (i_stall),
        .o_cmd            (cmd),
        .i_status         (status)
    );

    sha256_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_msg_byte    (i_msg_byte),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_digest_word (o_digest_word)
    );

endmodule
`default_nettype wire

// File: design/sha256_checker.sv
`default_nettype none
`include "assert_macros.svh"
module sha256_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_stall,
    input wire        o_valid,
    input wire        i_stall,
    input wire [31:0] o_digest_word,
    input wire [2:0]  o_word_index,
    input wire        o_last_word
);
    // A stalled result word holds its payload.
    `ASSERT_CLK(a_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(o_digest_word) && $stable(o_word_index), "stalled word changed")
    // Last marker exactly on index seven.
    `ASSERT_CLK(a_last, i_clk, i_rst_n, o_valid |-> (o_last_word == (o_word_index == 3'd7)), "last marker wrong")
    // Words of a digest come in order.
    `ASSERT_CLK(a_order, i_clk, i_rst_n, o_valid && !i_stall && !o_last_word |=> o_valid && o_word_index == $past(o_word_index) + 3'd1, "index out of order")
    // Intake is closed while a digest is out.
    `ASSERT_CLK(a_noin, i_clk, i_rst_n, o_valid |-> o_stall, "input open during output")
    // Nothing is shown during reset.
    `ASSERT_ALWAYS(a_rst, i_clk, !i_rst_n |=> !o_valid, "valid after reset")
endmodule

bind sha256_stream_hasher sha256_checker u_chk (.*);
`default_nettype wire

// File: tb/sv/sha256_stream_hasher_test.sv
`default_nettype none
module sha256_stream_hasher_test;

    localparam int HOLD_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 200;

    typedef struct packed {
        logic [7:0] msg_byte;
        logic       has_byte;
        logic       end_of_message;
    } t_byte_word;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_digest_word;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_msg_byte;
    logic        i_has_byte;
    logic        i_end_of_message;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    sha256_stream_hasher dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_msg_byte(i_msg_byte), .i_has_byte(i_has_byte),
        .i_end_of_message(i_end_of_message),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_digest_word(o_digest_word), .o_word_index(o_word_index),
        .o_last_word(o_last_word)
    );

    // Hashing state of the checker.
    logic [31:0] hash_chain [8];
    logic [7:0]  hash_block [64];
    logic [60:0] hash_count;

    t_byte_word   pending_words [$];
    t_digest_word expected_digests [$];
    int errors = 0;
    int messages_done = 0;
    int words_sent = 0;
    bit quiet_phase = 0;
    bit hold_request = 0;
    bit pause_request = 0;
    bit stim_done = 0;

    function automatic logic [31:0] ror32(input logic [31:0] v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    // One SHA-256 compression of hash_block into hash_chain.
    task automatic compress_hash_block();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
        for (int r = 0; r < 16; r++) begin
            w[r] = {hash_block[4*r], hash_block[4*r+1], hash_block[4*r+2],
                    hash_block[4*r+3]};
        end
        for (int r = 16; r < 64; r++) begin
            s0 = ror32(w[r-15], 7) ^ ror32(w[r-15], 18) ^ (w[r-15] >> 3);
            s1 = ror32(w[r-2], 17) ^ ror32(w[r-2], 19) ^ (w[r-2] >> 10);
            w[r] = s1 + w[r-7] + s0 + w[r-16];
        end
        a = hash_chain[0]; b = hash_chain[1]; c = hash_chain[2];
        d = hash_chain[3]; e = hash_chain[4]; f = hash_chain[5];
        g = hash_chain[6]; h = hash_chain[7];
        for (int r = 0; r < 64; r++) begin
            t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) +
                 ((e & f) ^ (~e & g)) + w[r] + sha256_pkg::ROUND_K[r];
            t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) +
                 ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hash_chain[0] += a; hash_chain[1] += b; hash_chain[2] += c;
        hash_chain[3] += d; hash_chain[4] += e; hash_chain[5] += f;
        hash_chain[6] += g; hash_chain[7] += h;
    endtask

    // Advance the hash on one accepted word and queue any digest it ends.
    task automatic hash_accept(input t_byte_word bw);
        int fill;
        logic [63:0] bits;
        t_digest_word dw;
        if (bw.has_byte) begin
            fill = int'(hash_count[5:0]);
            hash_block[fill] = bw.msg_byte;
            hash_count = hash_count + 1'b1;
            if (fill == 63) compress_hash_block();
        end
        if (bw.end_of_message) begin
            fill = int'(hash_count[5:0]);
            hash_block[fill] = sha256_pkg::PAD_BYTE;
            for (int j = fill + 1; j < 64; j++) hash_block[j] = 8'h00;
            if (fill >= int'(sha256_pkg::LEN_POS)) begin
                compress_hash_block();
                for (int j = 0; j < 64; j++) hash_block[j] = 8'h00;
            end
            bits = {hash_count, 3'b000};
            for (int j = 0; j < 8; j++) hash_block[56 + j] = bits[63 - 8*j -: 8];
            compress_hash_block();
            for (int j = 0; j < 8; j++) begin
                dw.digest_word = hash_chain[j];
                dw.word_index = 3'(j);
                dw.last_word = (j == 7);
                expected_digests.push_back(dw);
            end
            hash_chain = sha256_pkg::INIT_H;
            hash_count = '0;
        end
    endtask

    function automatic t_byte_word make_word(input logic [7:0] b, input bit has,
                                             input bit fin);
        t_byte_word bw;
        bw.msg_byte = b; bw.has_byte = has; bw.end_of_message = fin;
        return bw;
    endfunction

    // Queue a message of the given length with random bytes and occasional empty words.
    task automatic queue_message(input int len, input bit fin_with_byte);
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 19) == 0) pending_words.push_back(make_word(8'($urandom), 0, 0));
            pending_words.push_back(make_word(8'($urandom),
                                    1, fin_with_byte && (k == len - 1)));
        end
        if (!fin_with_byte || len == 0)
            pending_words.push_back(make_word(8'($urandom), 0, 1));
    endtask

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Driver.
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 0;
        end else begin
            if (i_valid && !o_stall) begin
                hash_accept({i_msg_byte, i_has_byte, i_end_of_message});
                words_sent++;
            end
            if (!i_valid || !o_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 0;
                end else if (pending_words.size() > 0 && !pause_request) begin
                    t_byte_word bw;
                    bw = pending_words.pop_front();
                    i_valid <= 1;
                    i_msg_byte <= bw.msg_byte;
                    i_has_byte <= bw.has_byte;
                    i_end_of_message <= bw.end_of_message;
                    if (!quiet_phase && $urandom_range(0, 7) == 0)
                        send_gap = $urandom_range(1, 7);
                end else begin
                    i_valid <= 0;
                end
            end
        end
    end

    // Monitor and receiver stall.
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                t_digest_word got, want;
                got = {o_digest_word, o_word_index, o_last_word};
                if (expected_digests.size() == 0) begin
                    $error("unexpected digest word %h", got.digest_word);
                    errors++;
                end else begin
                    want = expected_digests.pop_front();
                    if (got.digest_word !== want.digest_word) begin
                        $error("digest_word expected %h got %h",
                               want.digest_word, got.digest_word);
                        errors++;
                    end
                    if (got.word_index !== want.word_index) begin
                        $error("word_index expected %0d got %0d",
                               want.word_index, got.word_index);
                        errors++;
                    end
                    if (got.last_word !== want.last_word) begin
                        $error("last_word expected %0d got %0d",
                               want.last_word, got.last_word);
                        errors++;
                    end
                    if (want.last_word) messages_done++;
                end
            end
            if (hold_request) begin
                stall_left = 400;
                hold_request <= 0;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1;
            end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 7);
                i_stall <= 1;
            end else begin
                i_stall <= 0;
            end
        end
    end

    // Watchdog on cycles without any accepted word.
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > HOLD_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        i_rst_n = 0; i_valid = 0; i_stall = 0;
        i_msg_byte = 0; i_has_byte = 0; i_end_of_message = 0;
        hash_chain = sha256_pkg::INIT_H;
        hash_count = '0;
        for (int j = 0; j < 64; j++) hash_block[j] = 8'h00;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;

        // Directed: empty words, empty message, extreme bytes, byte with end.
        pending_words.push_back(make_word(8'hff, 0, 0));
        pending_words.push_back(make_word(8'h00, 0, 1));
        pending_words.push_back(make_word(8'h00, 1, 0));
        pending_words.push_back(make_word(8'hff, 1, 1));
        pending_words.push_back(make_word(8'h80, 1, 0));
        pending_words.push_back(make_word(8'h7f, 1, 0));
        pending_words.push_back(make_word(8'h55, 0, 1));

        // Long receiver hold while the sender keeps offering bytes. The long
        // message fills one block and ends with 56 bytes pending, so its
        // padding needs the extra length-only block.
        hold_request = 1;
        queue_message(120, 1);
        wait (pending_words.size() == 0 && !i_valid && expected_digests.size() == 0);

        // Short message; the pause request is set and cleared in the same time step, so the sender does not pause.
        pause_request = 1;
        queue_message($urandom_range(1, 4), 1);
        pause_request = 0;
        wait (pending_words.size() == 0 && !i_valid && expected_digests.size() == 0);

        // Random short messages.
        for (int m = 0; m < 2; m++) queue_message($urandom_range(0, 5), $urandom_range(0, 1));
        wait (pending_words.size() == 0);
        quiet_phase = 1;
        queue_message($urandom_range(0, 5), $urandom_range(0, 1));
        wait (pending_words.size() == 0 && !i_valid);
        wait (expected_digests.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d byte words, checked %0d digests.", words_sent, messages_done);
        if (errors == 0 && expected_digests.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
`default_nettype wire
